@@ rtl/core/qat_pkg.sv @@
// qat_pkg: shared types and constants of the quoted argument tokenizer.
// Holds the character class codes passed from the front part to the back part.
// No dependencies.
package qat_pkg;

  // Character classes that the front part hands to the back part.
  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_BLANK,
    CLS_DQUOTE,
    CLS_SQUOTE,
    CLS_BSLASH,
    CLS_OTHER
  } cls_t;

  localparam int unsigned DEF_MAX_ARGS    = 32;
  localparam int unsigned DEF_MAX_LINE    = 4096;
  localparam int unsigned DEF_QUEUE_DEPTH = 4;

  localparam logic [5:0]  MAX_ARGS_RESET = 6'd32;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

@@ rtl/core/quoted_argument_tokenizer_top.sv @@
// Quoted argument tokenizer: one result beat for every character beat.
// Path: an accepted character is written into the queue, then popped into the registered result beat.
// Throughput: one character per cycle while the queue is not full; res_ready can stall the result side.
// Reset (rst, synchronous) empties the queue, clears the scanner, sets max_args to 32.
module quoted_argument_tokenizer_top #(
  parameter int unsigned MAX_ARGS    = qat_pkg::DEF_MAX_ARGS,
  parameter int unsigned MAX_LINE    = qat_pkg::DEF_MAX_LINE,
  parameter int unsigned QUEUE_DEPTH = qat_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel: one register, the argument limit.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  max_args,
  // Character channel.
  input  logic        char_valid,
  output logic        char_ready,
  input  logic [7:0]  char_code,
  // Result channel.
  output logic        res_valid,
  input  logic        res_ready,
  output logic [11:0] position,
  output logic        arg_start,
  output logic        terminate,
  output logic [4:0]  arg_index,
  output logic        line_done,
  output logic [5:0]  arg_count
);

  // The front part classifies each character beat and pushes the class into
  // a short queue. The back part pops a class whenever its result register is
  // free or being emptied, so a stalled result side does not stop the
  // character side until the queue fills.
  logic          push;
  qat_pkg::cls_t push_cls;
  logic          queue_full;
  logic          queue_not_empty;
  logic          pop;
  qat_pkg::cls_t pop_cls;

  // The limit register is always writable; the user must write it only while idle, the block does not enforce this.
  assign cfg_ready = 1'b1;

  qat_front u_front (
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .queue_full (queue_full),
    .push       (push),
    .push_cls   (push_cls)
  );

  qat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cls  (push_cls),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .pop       (pop),
    .pop_cls   (pop_cls)
  );

  // The back part holds the scanner state, the argument limit and the
  // registered result beat.
  qat_back #(
    .MAX_ARGS (MAX_ARGS),
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_data        (max_args),
    .queue_not_empty (queue_not_empty),
    .pop_cls         (pop_cls),
    .pop             (pop),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .position        (position),
    .arg_start       (arg_start),
    .terminate       (terminate),
    .arg_index       (arg_index),
    .line_done       (line_done),
    .arg_count       (arg_count)
  );

endmodule

@@ rtl/core/qat_front.sv @@
// qat_front: accepts character beats and sorts each into a class code.
// Depends on qat_pkg; feeds qat_queue.
module qat_front (
  input  logic              char_valid,
  output logic              char_ready,
  input  logic [7:0]        char_code,
  input  logic              queue_full,
  output logic              push,
  output qat_pkg::cls_t     push_cls
);

  assign char_ready = !queue_full;
  assign push       = char_valid && !queue_full;

  always_comb begin
    if (char_code == qat_pkg::CH_NUL) begin
      push_cls = qat_pkg::CLS_NUL;
    end else if (char_code == qat_pkg::CH_SPACE ||
                 (char_code >= qat_pkg::CH_TAB && char_code <= qat_pkg::CH_CR)) begin
      push_cls = qat_pkg::CLS_BLANK;
    end else if (char_code == qat_pkg::CH_DQUOTE) begin
      push_cls = qat_pkg::CLS_DQUOTE;
    end else if (char_code == qat_pkg::CH_SQUOTE) begin
      push_cls = qat_pkg::CLS_SQUOTE;
    end else if (char_code == qat_pkg::CH_BSLASH) begin
      push_cls = qat_pkg::CLS_BSLASH;
    end else begin
      push_cls = qat_pkg::CLS_OTHER;
    end
  end

endmodule

@@ rtl/core/qat_queue.sv @@
// qat_queue: short first-in first-out queue of class codes between front and back.
// Depends on qat_pkg.
module qat_queue #(
  parameter int unsigned DEPTH = qat_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qat_pkg::cls_t  push_cls,
  output logic           full,
  output logic           not_empty,
  input  logic           pop,
  output qat_pkg::cls_t  pop_cls
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  qat_pkg::cls_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == FULL_COUNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cls   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_COUNT)
    else $error("queue count beyond depth");

endmodule

@@ rtl/core/qat_back.sv @@
// qat_back: argument scanner state, limit register and registered result beat.
// Depends on qat_pkg; takes class codes from qat_queue.
module qat_back #(
  parameter int unsigned MAX_ARGS = qat_pkg::DEF_MAX_ARGS,
  parameter int unsigned MAX_LINE = qat_pkg::DEF_MAX_LINE
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [5:0]     cfg_data,
  input  logic           queue_not_empty,
  input  qat_pkg::cls_t  pop_cls,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [11:0]    position,
  output logic           arg_start,
  output logic           terminate,
  output logic [4:0]     arg_index,
  output logic           line_done,
  output logic [5:0]     arg_count
);

  localparam logic [5:0]  ARG_CAP = 6'((MAX_ARGS > 32) ? 32 : MAX_ARGS);
  localparam logic [11:0] POS_CAP = 12'(((MAX_LINE - 1) > 4095) ? 4095 : (MAX_LINE - 1));

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_UNQUOTED,
    MODE_QUOTED
  } mode_t;

  mode_t       mode, mode_next;
  logic        sq_odd, sq_odd_next;
  logic        dq_odd, dq_odd_next;
  logic        escape, escape_next;
  logic        pending, pending_next;
  logic [5:0]  found, found_next;
  logic [11:0] char_pos, char_pos_next;
  logic [5:0]  max_args;
  logic [5:0]  limit;
  logic        start_c, term_c, done_c;
  logic [4:0]  idx_c;
  logic [4:0]  found_m1;
  logic        hidden;
  logic        is_quote;

  assign pop      = queue_not_empty && (!res_valid || res_ready);
  assign limit    = (max_args > ARG_CAP) ? ARG_CAP : max_args;
  assign found_m1 = 5'(found - 6'd1);
  assign is_quote = (pop_cls == qat_pkg::CLS_DQUOTE) || (pop_cls == qat_pkg::CLS_SQUOTE);

  always_comb begin
    mode_next     = mode;
    sq_odd_next   = sq_odd;
    dq_odd_next   = dq_odd;
    escape_next   = escape;
    pending_next  = pending;
    found_next    = found;
    char_pos_next = char_pos;
    start_c       = 1'b0;
    term_c        = 1'b0;
    done_c        = 1'b0;
    idx_c         = '0;
    hidden        = 1'b0;
    if (pop_cls == qat_pkg::CLS_NUL) begin
      // End of line: an empty quoted argument opened just before still reports its start.
      done_c = 1'b1;
      if (mode == MODE_QUOTED && pending) begin
        start_c = 1'b1;
        idx_c   = found_m1;
      end
      mode_next     = MODE_BETWEEN;
      sq_odd_next   = 1'b0;
      dq_odd_next   = 1'b0;
      escape_next   = 1'b0;
      pending_next  = 1'b0;
      found_next    = '0;
      char_pos_next = '0;
    end else begin
      unique case (mode)
        MODE_BETWEEN: begin
          if (pop_cls != qat_pkg::CLS_BLANK && found < limit) begin
            found_next = found + 6'd1;
            if (is_quote) begin
              mode_next    = MODE_QUOTED;
              sq_odd_next  = (pop_cls == qat_pkg::CLS_SQUOTE);
              dq_odd_next  = (pop_cls == qat_pkg::CLS_DQUOTE);
              escape_next  = 1'b0;
              pending_next = 1'b1;
            end else begin
              mode_next = MODE_UNQUOTED;
              start_c   = 1'b1;
              idx_c     = found[4:0];
            end
          end
        end
        MODE_UNQUOTED: begin
          if (pop_cls == qat_pkg::CLS_BLANK) begin
            term_c    = 1'b1;
            idx_c     = found_m1;
            mode_next = MODE_BETWEEN;
          end
        end
        MODE_QUOTED: begin
          if (pending) begin
            start_c      = 1'b1;
            pending_next = 1'b0;
          end
          // A backslash, and the character right after one, are not counted.
          hidden = (pop_cls == qat_pkg::CLS_BSLASH) || escape;
          if (!hidden) begin
            sq_odd_next = sq_odd ^ (pop_cls == qat_pkg::CLS_SQUOTE);
            dq_odd_next = dq_odd ^ (pop_cls == qat_pkg::CLS_DQUOTE);
          end
          if (!sq_odd_next && !dq_odd_next) begin
            term_c    = 1'b1;
            mode_next = MODE_BETWEEN;
          end
          escape_next = (pop_cls == qat_pkg::CLS_BSLASH);
          if (start_c || term_c) begin
            idx_c = found_m1;
          end
        end
        default: begin
          mode_next = MODE_BETWEEN;
        end
      endcase
      char_pos_next = (char_pos < POS_CAP) ? char_pos + 12'd1 : POS_CAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_BETWEEN;
      sq_odd    <= 1'b0;
      dq_odd    <= 1'b0;
      escape    <= 1'b0;
      pending   <= 1'b0;
      found     <= '0;
      char_pos  <= '0;
      max_args  <= qat_pkg::MAX_ARGS_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_args <= cfg_data;
      end
      if (pop) begin
        mode      <= mode_next;
        sq_odd    <= sq_odd_next;
        dq_odd    <= dq_odd_next;
        escape    <= escape_next;
        pending   <= pending_next;
        found     <= found_next;
        char_pos  <= char_pos_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      position  <= char_pos;
      arg_start <= start_c;
      terminate <= term_c;
      arg_index <= idx_c;
      line_done <= done_c;
      arg_count <= done_c ? found : found_next;
    end
  end

  a_found_cap: assert property (@(posedge clk) disable iff (rst) found <= 6'd32)
    else $error("argument count beyond 32");

  a_escape_quoted: assert property (@(posedge clk) disable iff (rst)
    escape |-> mode == MODE_QUOTED)
    else $error("escape armed outside a quoted argument");

  a_pending_quoted: assert property (@(posedge clk) disable iff (rst)
    pending |-> mode == MODE_QUOTED)
    else $error("start pending outside a quoted argument");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    pop && pop_cls == qat_pkg::CLS_NUL |=> found == '0 && char_pos == '0 &&
      mode == MODE_BETWEEN && line_done)
    else $error("end of line did not clear scanner state");

  a_no_term_on_nul: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(terminate && line_done))
    else $error("end of line reported as terminator");

endmodule
